// File: design/hpd_pkg.sv
`timescale 1ns / 1ps
package hpd_pkg;

  localparam int FULL_SCALE_MV = 3300;
  localparam int MV_W          = 16;
  localparam int TICK_W        = 8;
  localparam int PROD_W        = MV_W + TICK_W;
  localparam int FS_LOG        = $clog2(FULL_SCALE_MV);
  localparam int DIV_SH        = PROD_W + FS_LOG;
  localparam int RECIP_W       = PROD_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_SH) + 64'(FULL_SCALE_MV) - 64'd1) / 64'(FULL_SCALE_MV);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_DRIVE = 1'b1;

  localparam int REG_PERIOD = 0;
  localparam int REG_DEAD   = 1;

  localparam logic [TICK_W-1:0] PERIOD_RST = 8'd100;
  localparam logic [TICK_W-1:0] DEAD_RST   = 8'd100;

  typedef struct packed {
    logic              cmd;
    logic              dir;
    logic [TICK_W-1:0] duty;
  } hpd_item_t;

  typedef struct packed {
    logic              braking;
    logic              reverse_dir;
    logic [TICK_W-1:0] duty_now;
    logic              pwm_level;
    logic              bridge_in2;
    logic              bridge_in1;
  } hpd_result_t;

endpackage

// File: design/hbridge_pwm_drive.sv
`timescale 1ns / 1ps
// Path: product, scaled quotient, queue and output registers, in that order.
// Throughput: one transaction per cycle while out_tready takes each result,
// set by the single-issue back end.
// Reset: synchronous, active low; clears the bridge state, empties the queue and
// sets both period and dead time to 100 ticks.
module hbridge_pwm_drive (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] command_mv
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] bridge_in1, [1] bridge_in2, [2] pwm_level,
                                  // [10:3] duty_now, [11] reverse_dir, [12] braking
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import hpd_pkg::*;

  logic [TICK_W-1:0] period_r;
  logic [TICK_W-1:0] dead_r;
  logic              push;
  logic              push_ready;
  hpd_item_t         push_item;
  logic              pop;
  logic              pop_valid;
  hpd_item_t         pop_item;
  hpd_result_t       result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      dead_r   <= DEAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        1'(REG_PERIOD): period_r <= cfg_wdata;
        1'(REG_DEAD):   dead_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  hpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_mv      (in_tdata),
    .period     (period_r),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  hpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (pop_valid),
    .pop        (pop),
    .item       (pop_item),
    .period     (period_r),
    .dead       (dead_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  assign out_tdata = {3'b000, result};

endmodule

// File: design/hpd_front.sv
`timescale 1ns / 1ps
module hpd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [hpd_pkg::MV_W-1:0]  in_mv,
  input  logic [hpd_pkg::TICK_W-1:0] period,
  output logic                      push,
  input  logic                      push_ready,
  output hpd_pkg::hpd_item_t        push_item
);
  import hpd_pkg::*;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_cmd_r;
  logic              s1_neg_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic              s2_v_r, s2_v_nxt;
  logic              s2_cmd_r;
  logic              s2_neg_r;
  logic [PROD_W-1:0] s2_quot_r;

  logic [MV_W-1:0]           mag;
  logic [PROD_W+RECIP_W-1:0] scaled;
  logic [PROD_W-1:0]         quot;
  logic                      s1_adv;
  logic                      in_take;

  assign mag     = in_mv[MV_W-1] ? (~in_mv + 1'b1) : in_mv;
  assign scaled  = (PROD_W+RECIP_W)'(s1_prod_r) * (PROD_W+RECIP_W)'(RECIP);
  assign quot    = PROD_W'(scaled >> DIV_SH);

  assign push    = s2_v_r && push_ready;
  assign s1_adv  = !s2_v_r || push;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_take = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    if (s1_adv) begin
      s2_v_nxt = s1_v_r;
    end
    if (in_ready) begin
      s1_v_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_cmd;
      s1_neg_r  <= in_mv[MV_W-1];
      s1_prod_r <= PROD_W'(mag) * PROD_W'(period);
    end
    if (s1_adv && s1_v_r) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_neg_r  <= s1_neg_r;
      s2_quot_r <= quot;
    end
  end

  always_comb begin
    push_item.cmd = s2_cmd_r;
    push_item.dir = s2_neg_r && (s2_quot_r != '0);
    if (s2_quot_r > PROD_W'(period)) begin
      push_item.duty = period;
    end else begin
      push_item.duty = s2_quot_r[TICK_W-1:0];
    end
  end

endmodule

// File: design/hpd_queue.sv
`timescale 1ns / 1ps
module hpd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               push_ready,
  input  hpd_pkg::hpd_item_t push_item,
  input  logic               pop,
  output logic               pop_valid,
  output hpd_pkg::hpd_item_t pop_item
);
  import hpd_pkg::*;

  hpd_item_t      mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign pop_valid  = count_r != '0;
  assign push_ready = (count_r != (QAW+1)'(QDEPTH)) || pop;
  assign pop_item   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

// File: design/hpd_back.sv
`timescale 1ns / 1ps
module hpd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  output logic                       pop,
  input  hpd_pkg::hpd_item_t         item,
  input  logic [hpd_pkg::TICK_W-1:0] period,
  input  logic [hpd_pkg::TICK_W-1:0] dead,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hpd_pkg::hpd_result_t       out_result
);
  import hpd_pkg::*;

  logic              dir_r, dir_nxt;
  logic              drv_r, drv_nxt;
  logic [TICK_W-1:0] duty_r, duty_nxt;
  logic [TICK_W-1:0] cnt_r, cnt_nxt;
  logic [TICK_W-1:0] bcnt_r, bcnt_nxt;
  logic              brk_r, brk_nxt;
  logic [TICK_W-1:0] pduty_r, pduty_nxt;
  logic              pdir_r, pdir_nxt;
  logic              ov_r, ov_nxt;
  hpd_result_t       res_r, res_nxt;

  logic [TICK_W:0]   cnt_inc;
  logic [TICK_W-1:0] bcnt_dec;
  logic [TICK_W-1:0] duty_clamp;
  logic              live;

  assign pop        = item_valid && (!ov_r || out_ready);
  assign out_valid  = ov_r;
  assign out_result = res_r;
  assign cnt_inc    = {1'b0, cnt_r} + 1'b1;
  assign bcnt_dec   = (bcnt_r != '0) ? bcnt_r - 1'b1 : bcnt_r;

  always_comb begin
    dir_nxt   = dir_r;
    drv_nxt   = drv_r;
    duty_nxt  = duty_r;
    cnt_nxt   = cnt_r;
    bcnt_nxt  = bcnt_r;
    brk_nxt   = brk_r;
    pduty_nxt = pduty_r;
    pdir_nxt  = pdir_r;
    if (pop) begin
      unique case (item.cmd)
        CMD_DRIVE: begin
          if (brk_r) begin
            pduty_nxt = item.duty;
            pdir_nxt  = item.dir;
          end else if ((item.dir != dir_r) && (dead != '0)) begin
            pduty_nxt = item.duty;
            pdir_nxt  = item.dir;
            bcnt_nxt  = dead;
            brk_nxt   = 1'b1;
          end else begin
            dir_nxt  = item.dir;
            duty_nxt = item.duty;
            drv_nxt  = 1'b1;
            brk_nxt  = 1'b0;
            bcnt_nxt = '0;
          end
        end
        CMD_TICK: begin
          cnt_nxt = (cnt_inc >= {1'b0, period}) ? '0 : cnt_inc[TICK_W-1:0];
          if (brk_r) begin
            if (bcnt_dec == '0) begin
              dir_nxt  = pdir_r;
              duty_nxt = pduty_r;
              drv_nxt  = 1'b1;
              brk_nxt  = 1'b0;
              bcnt_nxt = '0;
            end else begin
              bcnt_nxt = bcnt_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    duty_clamp = (duty_nxt > period) ? period : duty_nxt;
    live       = drv_nxt && !brk_nxt;
    res_nxt.bridge_in1  = live && !dir_nxt;
    res_nxt.bridge_in2  = live && dir_nxt;
    res_nxt.pwm_level   = live && (cnt_nxt < duty_clamp);
    res_nxt.duty_now    = duty_clamp;
    res_nxt.reverse_dir = dir_nxt;
    res_nxt.braking     = brk_nxt;
    ov_nxt = ov_r;
    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= 1'b0;
      drv_r   <= 1'b0;
      duty_r  <= '0;
      cnt_r   <= '0;
      bcnt_r  <= '0;
      brk_r   <= 1'b0;
      pduty_r <= '0;
      pdir_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      dir_r   <= dir_nxt;
      drv_r   <= drv_nxt;
      duty_r  <= duty_nxt;
      cnt_r   <= cnt_nxt;
      bcnt_r  <= bcnt_nxt;
      brk_r   <= brk_nxt;
      pduty_r <= pduty_nxt;
      pdir_r  <= pdir_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule
